@@ rtl/core/gma_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gma_pkg
// Shared types and constants of the coolant gauge moving-average filter.
// ----------------------------------------------------------------------------
package gma_pkg;

  localparam int GMA_DEPTH = 10;
  localparam int SAMPLE_W  = 8;
  localparam int CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] RAW_OFFSET_RST = 8'd48;
  localparam logic [SAMPLE_W-1:0] BAND_LOW_RST   = 8'd80;
  localparam logic [SAMPLE_W-1:0] BAND_HIGH_RST  = 8'd105;
  localparam logic [SAMPLE_W-1:0] BAND_SHOW_RST  = 8'd85;

  // Gain curve above the band: floor(avg * 451 / 200) - 150.
  // The quotient by 200 is a multiply by a rounded-up reciprocal; for an
  // 8-bit average the error stays below one step, so the floor is exact.
  localparam int CURVE_NUM   = 451;
  localparam int CURVE_DEN   = 200;
  localparam int CURVE_SHIFT = 16;
  localparam int CURVE_MUL   = (CURVE_NUM * (2 ** CURVE_SHIFT) + CURVE_DEN - 1) / CURVE_DEN;
  localparam int CURVE_BIAS  = 150;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_OFFSET = 2'd0,
    CFG_BAND_LOW   = 2'd1,
    CFG_BAND_HIGH  = 2'd2,
    CFG_BAND_SHOW  = 2'd3
  } cfg_reg_t;

  // Commands broadcast to every cell of the sample ring.
  typedef struct packed {
    logic wr;      // accepted beat with ignition on
    logic fill;    // ignition was off; with wr (off-to-on edge) every cell takes the sample
    logic rewind;  // accepted beat with ignition off: token back to cell 0
  } cell_ctl_t;

endpackage : gma_pkg
`default_nettype wire

@@ rtl/core/gma_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gma_cell
// One slot of the sample ring with its share of the write token.
// ----------------------------------------------------------------------------
module gma_cell #(
  parameter bit FIRST = 1'b0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gma_pkg::cell_ctl_t           ctl,
  input  wire logic [gma_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                         tok_in,
  output logic                              tok_out,
  output logic [gma_pkg::SAMPLE_W-1:0]      old
);
  import gma_pkg::*;

  logic                tok_r, tok_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;

  always_comb begin
    tok_nxt    = tok_r;
    sample_nxt = sample_r;
    if (ctl.rewind) begin
      tok_nxt = FIRST;
    end else if (ctl.wr) begin
      tok_nxt = tok_in;
      if (tok_r || ctl.fill) begin
        sample_nxt = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= FIRST;
      sample_r <= '0;
    end else begin
      tok_r    <= tok_nxt;
      sample_r <= sample_nxt;
    end
  end

  assign tok_out = tok_r;
  // Only the cell holding the token shows its sample, so the ring can OR them.
  assign old     = tok_r ? sample_r : '0;

endmodule : gma_cell
`default_nettype wire

@@ rtl/core/gma_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gma_map
// Three-stage pipeline from ring sum to display value: average, band
// selection and gain curve, with the output register as last stage.
// ----------------------------------------------------------------------------
module gma_map #(
  parameter int DEPTH = gma_pkg::GMA_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                sum_valid,
  output logic                                     sum_take,
  input  wire logic                                sum_off,
  input  wire logic [$clog2(DEPTH*255+1)-1:0]      sum,
  input  wire logic [gma_pkg::SAMPLE_W-1:0]        band_low,
  input  wire logic [gma_pkg::SAMPLE_W-1:0]        band_high,
  input  wire logic [gma_pkg::SAMPLE_W-1:0]        band_show,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [gma_pkg::SAMPLE_W-1:0]             out_shown_temp
);
  import gma_pkg::*;

  localparam int SUM_W = $clog2(DEPTH * 255 + 1);
  // Rounded-up reciprocal of DEPTH; DIV_K is large enough that
  // (sum * RECIP) >> DIV_K equals floor(sum / DEPTH) for every ring sum.
  localparam int DIV_K    = $clog2(DEPTH * 255 * DEPTH);
  localparam int RECIP    = (2 ** DIV_K + DEPTH - 1) / DEPTH;
  localparam int P2_W     = SUM_W + DIV_K;
  localparam int CURVE_W  = $clog2(CURVE_MUL + 1);
  localparam int P3_W     = SAMPLE_W + CURVE_W;
  localparam int SCALED_W = P3_W - CURVE_SHIFT;

  typedef enum logic [1:0] {
    SEL_PASS  = 2'd0,
    SEL_BAND  = 2'd1,
    SEL_CURVE = 2'd2,
    SEL_OFF   = 2'd3
  } map_sel_t;

  logic en2, en3, en4;

  logic            v2_r, off2_r;
  logic [P2_W-1:0] prod2_r;

  logic                v3_r;
  map_sel_t            sel3_r, sel3_nxt;
  logic [SAMPLE_W-1:0] avg3_r;
  logic [P3_W-1:0]     prod3_r;
  logic [SAMPLE_W-1:0] avg;

  logic                v4_r;
  logic [SAMPLE_W-1:0] shown_r, shown_nxt;
  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] over;
  logic [SAMPLE_W-1:0] curve;

  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign sum_take = en2;

  // Stage 2: sum times reciprocal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && sum_valid) begin
      off2_r  <= sum_off;
      prod2_r <= P2_W'(sum) * P2_W'(RECIP);
    end
  end

  // Stage 3: average, band compare, curve product.
  assign avg = prod2_r[DIV_K +: SAMPLE_W];

  always_comb begin
    if (off2_r) begin
      sel3_nxt = SEL_OFF;
    end else if (avg >= band_low && avg <= band_high) begin
      sel3_nxt = SEL_BAND;
    end else if (avg > band_high) begin
      sel3_nxt = SEL_CURVE;
    end else begin
      sel3_nxt = SEL_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      sel3_r  <= sel3_nxt;
      avg3_r  <= avg;
      prod3_r <= P3_W'(avg) * P3_W'(CURVE_MUL);
    end
  end

  // Stage 4: curve offset with saturation, final selection.
  assign scaled = prod3_r[CURVE_SHIFT +: SCALED_W];
  assign over   = scaled - SCALED_W'(CURVE_BIAS);

  always_comb begin
    if (scaled <= SCALED_W'(CURVE_BIAS)) begin
      curve = '0;
    end else if (over > SCALED_W'(255)) begin
      curve = '1;
    end else begin
      curve = over[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    unique case (sel3_r)
      SEL_PASS:  shown_nxt = avg3_r;
      SEL_BAND:  shown_nxt = band_show;
      SEL_CURVE: shown_nxt = curve;
      SEL_OFF:   shown_nxt = '0;
      default:   shown_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      shown_r <= shown_nxt;
    end
  end

  assign out_valid      = v4_r;
  assign out_shown_temp = shown_r;

endmodule : gma_map
`default_nettype wire

@@ rtl/core/gauge_moving_average_map.sv @@
`default_nettype none
// Throughput: one beat per cycle unless out_stall holds the pipeline; the
//   ring of cells and the running sum update in the accept cycle, sum1_r
//   registers the sum, then the average and mapping run in three stages.
// Reset (synchronous, rst_n low): ring cleared to zero, write token at cell 0,
//   running sum zero, registers to their defaults, pipeline emptied.
// ----------------------------------------------------------------------------
// gauge_moving_average_map
// Coolant gauge filter: a ring of sample cells with a running sum, followed
// by the averaging and display mapping pipeline.
// ----------------------------------------------------------------------------
module gauge_moving_average_map #(
  parameter int DEPTH = gma_pkg::GMA_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gma_pkg::SAMPLE_W-1:0]  in_raw_temp,
  input  wire logic                          in_ign_on,
  input  wire logic                          in_ign_was_on,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gma_pkg::SAMPLE_W-1:0]       out_shown_temp,
  input  wire logic                          cfg_wr_en,
  input  wire logic [gma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gma_pkg::SAMPLE_W-1:0]  cfg_data
);
  import gma_pkg::*;

  localparam int SUM_W = $clog2(DEPTH * 255 + 1);

  logic [SAMPLE_W-1:0] raw_offset_r, band_low_r, band_high_r, band_show_r;

  logic                accept;
  logic [SAMPLE_W-1:0] sample;
  cell_ctl_t           ctl;
  logic [DEPTH-1:0]    tok;
  logic [SAMPLE_W-1:0] cell_old [DEPTH];
  logic [SAMPLE_W-1:0] old;

  logic [SUM_W-1:0] ring_sum_r, ring_sum_nxt;

  logic             v1_r, off1_r;
  logic [SUM_W-1:0] sum1_r;
  logic             en1, take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_offset_r <= RAW_OFFSET_RST;
      band_low_r   <= BAND_LOW_RST;
      band_high_r  <= BAND_HIGH_RST;
      band_show_r  <= BAND_SHOW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RAW_OFFSET: raw_offset_r <= cfg_data;
        CFG_BAND_LOW:   band_low_r   <= cfg_data;
        CFG_BAND_HIGH:  band_high_r  <= cfg_data;
        CFG_BAND_SHOW:  band_show_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign en1      = !v1_r || take;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;
  assign sample   = in_raw_temp - raw_offset_r;

  assign ctl.wr     = accept && in_ign_on;
  assign ctl.fill   = !in_ign_was_on;
  assign ctl.rewind = accept && !in_ign_on;

  // The write token travels around the ring; the last cell feeds the first.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    gma_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sample  (sample),
      .tok_in  (tok[(i + DEPTH - 1) % DEPTH]),
      .tok_out (tok[i]),
      .old     (cell_old[i])
    );
  end

  always_comb begin
    old = '0;
    for (int i = 0; i < DEPTH; i++) begin
      old = old | cell_old[i];
    end
  end

  always_comb begin
    ring_sum_nxt = ring_sum_r;
    if (ctl.wr) begin
      if (ctl.fill) begin
        ring_sum_nxt = SUM_W'(SUM_W'(sample) * SUM_W'(DEPTH));
      end else begin
        ring_sum_nxt = ring_sum_r - SUM_W'(old) + SUM_W'(sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_sum_r <= '0;
      v1_r       <= 1'b0;
    end else begin
      ring_sum_r <= ring_sum_nxt;
      if (en1) begin
        v1_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      off1_r <= !in_ign_on;
      sum1_r <= ring_sum_nxt;
    end
  end

  gma_map #(
    .DEPTH (DEPTH)
  ) u_map (
    .clk            (clk),
    .rst_n          (rst_n),
    .sum_valid      (v1_r),
    .sum_take       (take),
    .sum_off        (off1_r),
    .sum            (sum1_r),
    .band_low       (band_low_r),
    .band_high      (band_high_r),
    .band_show      (band_show_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_shown_temp (out_shown_temp)
  );

endmodule : gauge_moving_average_map
`default_nettype wire

@@ rtl/core/gma_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gma_checker
// Port-level checks of the gauge filter, bound to the top level.
// ----------------------------------------------------------------------------
module gma_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [gma_pkg::SAMPLE_W-1:0]  out_shown_temp
);

  // A stalled result beat holds its value.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shown_temp))
    else $error("stalled result beat changed");

  // Reset empties the pipeline and opens the input.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // The input only stalls when every stage is full and the output is held.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule : gma_checker

bind gauge_moving_average_map gma_checker u_gma_checker (.*);
`default_nettype wire
